### sv/sdf_pkg.sv
// Shared constants and controller/datapath interface types for the distance field block.
package sdf_pkg;

  localparam int MAX_SEGMENTS_DEF = 1024;
  localparam int COORD_BITS_DEF   = 16;
  localparam int FIELD_W          = 20;
  localparam int RADIUS_W         = 15;
  localparam int IN_DATA_W        = 144;
  localparam int OUT_DATA_W       = 24;
  localparam int ACC_W            = 52;
  localparam int ITER_N           = 26;
  localparam int ITER_W           = 5;

  localparam logic [RADIUS_W-1:0]       RADIUS_RESET = 15'd82;
  localparam logic signed [FIELD_W-1:0] FIELD_CAP    = 20'sd409600;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic load;
    logic clear;
    logic start;
    logic rd;
    logic diff;
    logic prod;
    logic sum;
    logic tsel;
    logic div_step;
    logic tmul;
    logic err;
    logic sq;
    logic acc;
    logic sqrt_step;
    logic minup;
    logic out_load;
  } sdf_cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
    logic t_direct;
  } sdf_stat_t;

endpackage

### sv/sdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/sdf_dp.sv
// Datapath: segment table, distance arithmetic, divider, square root and running minimum.
module sdf_dp import sdf_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  cfg_wr_en,
  input  logic [RADIUS_W-1:0]   cfg_wdata,
  input  sdf_cmd_t              cmd,
  output sdf_stat_t             stat,
  output logic [FIELD_W-1:0]    field_value,
  output logic                  table_empty
);

  localparam int CW    = (COORD_BITS > 16) ? 16 : COORD_BITS;
  localparam int MEM_W = 6 * CW;
  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  logic [CNT_W-1:0]          cnt_r;
  logic [IDX_W-1:0]          idx_r;
  logic [RADIUS_W-1:0]       radius_r;
  logic signed [15:0]        q_r   [3];
  logic signed [16:0]        d_r   [3];
  logic signed [16:0]        w_r   [3];
  logic signed [33:0]        dd_r  [3];
  logic signed [33:0]        wd_r  [3];
  logic [35:0]               len2_r;
  logic signed [35:0]        dot_r;
  logic [35:0]               rem_r;
  logic [26:0]               t_r;
  logic signed [44:0]        td_r  [3];
  logic signed [27:0]        e_r   [3];
  logic [ACC_W-1:0]          sq_r  [3];
  logic [ACC_W-1:0]          x_r;
  logic [ACC_W-1:0]          root_r;
  logic [ACC_W-1:0]          bit_r;
  logic signed [FIELD_W-1:0] best_r;
  logic [FIELD_W-1:0]        field_r;
  logic                      empty_r;

  logic [MEM_W-1:0]          wdata;
  logic [MEM_W-1:0]          rdata;
  logic signed [16:0]        rs    [3];
  logic signed [16:0]        re    [3];
  logic signed [44:0]        td_rnd[3];
  logic [36:0]               rem_sh;
  logic                      rem_ge;
  logic [ACC_W-1:0]          trial;
  logic [17:0]               dist_q12;
  logic signed [20:0]        val;
  logic                      t_zero;
  logic                      t_one;

  // Coordinates are kept at CW bits and sign-extended on the way out of the table.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      wdata[CW*i +: CW] = in_tdata[16*i +: CW];
    end
    for (int i = 0; i < 3; i++) begin
      rs[i]     = 17'(signed'(rdata[CW*i +: CW]));
      re[i]     = 17'(signed'(rdata[CW*(i+3) +: CW]));
      td_rnd[i] = td_r[i] + 45'sd131072;
    end
  end

  sdf_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load && (cnt_r < CNT_W'(MAX_SEGMENTS))),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (idx_r),
    .rdata (rdata)
  );

  assign t_zero = (len2_r == 36'd0) || (dot_r <= 36'sd0);
  assign t_one  = dot_r >= signed'(len2_r);
  assign rem_sh = {rem_r, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, len2_r};
  assign trial  = root_r + bit_r;
  assign dist_q12 = 18'((root_r + ACC_W'(128)) >> 8);
  assign val    = signed'({3'b000, dist_q12}) - signed'({6'b000000, radius_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      idx_r    <= '0;
      radius_r <= RADIUS_RESET;
    end else begin
      if (cfg_wr_en) begin
        radius_r <= cfg_wdata;
      end
      if (cmd.clear) begin
        cnt_r <= '0;
      end else if (cmd.load && (cnt_r < CNT_W'(MAX_SEGMENTS))) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.start) begin
        idx_r <= '0;
      end else if (cmd.minup) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best_r <= FIELD_CAP;
      for (int i = 0; i < 3; i++) begin
        q_r[i] <= 16'(signed'(in_tdata[16*(i+6) +: CW]));
      end
    end
    if (cmd.diff) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i] <= re[i] - rs[i];
        w_r[i] <= 17'(q_r[i]) - rs[i];
      end
    end
    if (cmd.prod) begin
      for (int i = 0; i < 3; i++) begin
        dd_r[i] <= d_r[i] * d_r[i];
        wd_r[i] <= w_r[i] * d_r[i];
      end
    end
    if (cmd.sum) begin
      len2_r <= 36'(unsigned'(dd_r[0])) + 36'(unsigned'(dd_r[1]))
              + 36'(unsigned'(dd_r[2]));
      dot_r  <= 36'(wd_r[0]) + 36'(wd_r[1]) + 36'(wd_r[2]);
    end
    if (cmd.tsel) begin
      rem_r <= unsigned'(dot_r);
      t_r   <= (!t_zero && t_one) ? 27'(1) << 26 : 27'd0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_ge ? 36'(rem_sh - {1'b0, len2_r}) : rem_sh[35:0];
      t_r   <= {t_r[25:0], rem_ge};
    end
    if (cmd.tmul) begin
      for (int i = 0; i < 3; i++) begin
        td_r[i] <= signed'({1'b0, t_r}) * d_r[i];
      end
    end
    if (cmd.err) begin
      for (int i = 0; i < 3; i++) begin
        e_r[i] <= 28'(signed'({w_r[i], 8'd0})) - 28'(signed'(td_rnd[i][44:18]));
      end
    end
    if (cmd.sq) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= ACC_W'(e_r[i] * e_r[i]);
      end
    end
    if (cmd.acc) begin
      x_r    <= sq_r[0] + sq_r[1] + sq_r[2];
      root_r <= '0;
      bit_r  <= ACC_W'(1) << (2 * (ITER_N - 1));
    end
    if (cmd.sqrt_step) begin
      if (x_r >= trial) begin
        x_r    <= x_r - trial;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.minup) begin
      if (val < 21'(best_r)) begin
        best_r <= val[FIELD_W-1:0];
      end
    end
    if (cmd.out_load) begin
      field_r <= best_r;
      empty_r <= (cnt_r == '0);
    end
  end

  assign stat.empty    = (cnt_r == '0);
  assign stat.last     = (CNT_W'(idx_r) + CNT_W'(1)) == cnt_r;
  assign stat.t_direct = t_zero || t_one;
  assign field_value   = field_r;
  assign table_empty   = empty_r;

endmodule

### sv/sdf_ctrl.sv
// Controller: item decode, per-segment sequencing and output register handshake.
module sdf_ctrl import sdf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic [1:0] in_tuser,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  sdf_stat_t stat,
  output sdf_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_DIFF  = 4'd2;
  localparam logic [3:0] S_PROD  = 4'd3;
  localparam logic [3:0] S_SUM   = 4'd4;
  localparam logic [3:0] S_TSEL  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_TMUL  = 4'd7;
  localparam logic [3:0] S_ERR   = 4'd8;
  localparam logic [3:0] S_SQ    = 4'd9;
  localparam logic [3:0] S_ACC   = 4'd10;
  localparam logic [3:0] S_SQRT  = 4'd11;
  localparam logic [3:0] S_MINUP = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0]        state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic              acc_in;
  logic              iter_end;

  assign in_tready  = (state_r == S_IDLE);
  assign acc_in     = in_tvalid && in_tready;
  assign out_tvalid = ovalid_r;
  assign iter_end   = (iter_r == ITER_W'(ITER_N - 1));

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          unique case (in_tuser)
            KIND_LOAD:  cmd.load  = 1'b1;
            KIND_CLEAR: cmd.clear = 1'b1;
            KIND_QUERY: begin
              cmd.start = 1'b1;
              state_nxt = stat.empty ? S_DONE : S_RD;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_PROD;
      end
      S_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_TSEL;
      end
      S_TSEL: begin
        cmd.tsel  = 1'b1;
        iter_nxt  = '0;
        state_nxt = stat.t_direct ? S_TMUL : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        iter_nxt     = iter_r + ITER_W'(1);
        if (iter_end) begin
          state_nxt = S_TMUL;
        end
      end
      S_TMUL: begin
        cmd.tmul  = 1'b1;
        state_nxt = S_ERR;
      end
      S_ERR: begin
        cmd.err   = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        iter_nxt  = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        iter_nxt      = iter_r + ITER_W'(1);
        if (iter_end) begin
          state_nxt = S_MINUP;
        end
      end
      S_MINUP: begin
        cmd.minup = 1'b1;
        state_nxt = stat.last ? S_DONE : S_RD;
      end
      S_DONE: begin
        // The result waits here until the output register is free.
        if (!ovalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      iter_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      iter_r   <= iter_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

### sv/segment_set_distance_field_top.sv
// Load and clear words are handled as they are accepted; a query visits each stored segment in turn,
// settling the parameter either by the clamp or by the 26-step divider.
// The 26-step square root and the divider are shared by all segments, one segment at a time.
// Throughput: one query in flight; the next word is taken once the result is in the output register.
// Reset (rst_n, synchronous, active low) empties the table, idles the sequencer and sets
// the wire radius to 82; table contents are not cleared.
module segment_set_distance_field_top import sdf_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, query_x, query_y, query_z
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // kind
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // field_value, zero padding
  output logic [OUT_DATA_W-1:0] out_tdata,
  // table_empty
  output logic [0:0]            out_tuser,
  input  logic                  cfg_wr_en,
  input  logic [RADIUS_W-1:0]   cfg_wdata
);

  sdf_cmd_t           cmd;
  sdf_stat_t          stat;
  logic [FIELD_W-1:0] field_value;
  logic               table_empty;

  sdf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sdf_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .stat        (stat),
    .field_value (field_value),
    .table_empty (table_empty)
  );

  assign out_tdata = {(OUT_DATA_W - FIELD_W)'(0), field_value};
  assign out_tuser = table_empty;

`ifndef SYNTH
  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == KIND_QUERY) |=> !in_tready)
    else $error("input accepted while a query is in progress");

  a_empty_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[FIELD_W-1:0] == FIELD_CAP))
    else $error("empty table result is not the cap");

  a_cap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (signed'(out_tdata[FIELD_W-1:0]) <= FIELD_CAP))
    else $error("result above the cap");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.clear, cmd.start, cmd.div_step, cmd.sqrt_step, cmd.out_load}))
    else $error("conflicting datapath commands");
`endif

endmodule

### sim/tb_segment_set_distance_field_top.sv
// Self-checking testbench for the segment set distance field block.
module tb_segment_set_distance_field_top;
  import sdf_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [1:0]       kind;
    logic [8:0][15:0] coord;  // sx, sy, sz, ex, ey, ez, qx, qy, qz from index 0 up
    bit               drain;
  } word_t;

  typedef struct {
    logic signed [FIELD_W-1:0] value;
    logic                      empty;
  } field_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid, in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid, out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_wr_en;
  logic [RADIUS_W-1:0] cfg_wdata;

  segment_set_distance_field_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_wr_en(cfg_wr_en), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  word_t  send_q[$];
  field_t field_q[$];
  longint seg_tab[1024][6];
  int     seg_cnt;
  logic [RADIUS_W-1:0] radius;
  int     errors;
  int     long_hold;
  int     gen_cnt;

  function automatic longint isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Distance from a point to one stored segment, in Q.12.
  function automatic longint wire_distance(int k, longint p[3]);
    longint d[3], w[3], len2, dotp, t, e;
    longint unsigned acc;
    len2 = 0;
    dotp = 0;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = seg_tab[k][3+i] - seg_tab[k][i];
      w[i] = p[i] - seg_tab[k][i];
      len2 += d[i] * d[i];
      dotp += w[i] * d[i];
    end
    if (len2 == 0 || dotp <= 0) t = 0;
    else if (dotp >= len2) t = 64'sd1 << 26;
    else t = (dotp <<< 26) / len2;
    for (int i = 0; i < 3; i++) begin
      // The product is rounded to nearest, ties upward, down to Q.20.
      e = w[i] * 256 - ((t * d[i] + (64'sd1 <<< 17)) >>> 18);
      acc += e * e;
    end
    return (isqrt(acc) + 128) >> 8;
  endfunction

  task automatic apply_word(word_t wd);
    longint p[3], best, v;
    field_t f;
    case (wd.kind)
      KIND_LOAD: if (seg_cnt < 1024) begin
        for (int i = 0; i < 6; i++) seg_tab[seg_cnt][i] = longint'($signed(wd.coord[i]));
        seg_cnt++;
      end
      KIND_CLEAR: seg_cnt = 0;
      KIND_QUERY: begin
        for (int i = 0; i < 3; i++) p[i] = longint'($signed(wd.coord[6+i]));
        best = 409600;
        for (int k = 0; k < seg_cnt; k++) begin
          v = wire_distance(k, p) - longint'(radius);
          if (v < best) best = v;
        end
        f.value = best[FIELD_W-1:0];
        f.empty = (seg_cnt == 0);
        field_q.push_back(f);
      end
      default: ;
    endcase
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 4, gap_left = 0;
  always @(posedge clk) begin : sender
    word_t wd;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) apply_word(send_q.pop_front());
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (send_q.size() > 0 && !(send_q[0].drain && field_q.size() != 0)) begin
          wd = send_q[0];
          in_tvalid <= 1'b1;
          in_tdata <= wd.coord;
          in_tuser <= wd.kind;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: windows of full readiness, light stalls and heavy stalls, plus a long hold.
  int rx_mode = 0, rx_win = 0;
  always @(posedge clk) begin : receiver
    field_t f;
    if (out_tvalid && out_tready && rst_n) begin
      if (field_q.size() == 0) begin
        $display("%0t: unexpected word, actual %0d empty %0b", $time,
                 $signed(out_tdata[FIELD_W-1:0]), out_tuser[0]);
        errors++;
      end else begin
        f = field_q.pop_front();
        if (out_tdata[FIELD_W-1:0] !== f.value) begin
          $display("%0t: field_value expected %0d actual %0d", $time, f.value,
                   $signed(out_tdata[FIELD_W-1:0]));
          errors++;
        end
        if (out_tuser[0] !== f.empty) begin
          $display("%0t: table_empty expected %0b actual %0b", $time, f.empty, out_tuser[0]);
          errors++;
        end
      end
    end
    if (rx_win == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_win = $urandom_range(20, 300);
    end else begin
      rx_win--;
    end
    if (long_hold > 0) begin
      long_hold--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_segment_set_distance_field_top NOT OK");
      $finish;
    end
  end

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 16'hFFFF));
      1: return 16'($signed($urandom_range(0, 4096)) - 2048);
      2: return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
      default: return 16'($signed($urandom_range(0, 16384)) - 8192);
    endcase
  endfunction

  task automatic push(logic [1:0] kind, logic [8:0][15:0] c, bit drain = 0);
    word_t wd;
    wd.kind = kind;
    wd.coord = c;
    wd.drain = drain;
    send_q.push_back(wd);
  endtask

  task automatic push_seg(int sx, int sy, int sz, int ex, int ey, int ez);
    push(KIND_LOAD, {48'h0, 16'(ez), 16'(ey), 16'(ex), 16'(sz), 16'(sy), 16'(sx)});
  endtask

  task automatic push_query(int qx, int qy, int qz);
    push(KIND_QUERY, {16'(qz), 16'(qy), 16'(qx), 96'h0});
  endtask

  task automatic push_random(bit drain);
    logic [8:0][15:0] c;
    int r;
    logic [1:0] kind;
    for (int i = 0; i < 9; i++) c[i] = rand_coord();
    r = $urandom_range(0, 99);
    if (gen_cnt > 12 && r < 15) kind = KIND_CLEAR;
    else if (r < 50) kind = KIND_LOAD;
    else if (r < 93) kind = KIND_QUERY;
    else if (r < 97) kind = KIND_CLEAR;
    else kind = KIND_SPARE;
    if (kind == KIND_LOAD) gen_cnt++;
    if (kind == KIND_CLEAR) gen_cnt = 0;
    push(kind, c, drain);
  endtask

  // Loads and clears give no result, so a short pause covers any word still in flight.
  task automatic wait_idle();
    do @(posedge clk); while (send_q.size() != 0 || in_tvalid || field_q.size() != 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_radius(logic [RADIUS_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wdata <= v;
    radius = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [RADIUS_W-1:0] settings[4];
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wdata = '0;
    errors = 0;
    long_hold = 0;
    seg_cnt = 0;
    gen_cnt = 0;
    radius = RADIUS_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, extremes, zero-length segment, clamping at both ends.
    push_query(0, 0, 0);
    push_seg(-32768, -32768, -32768, 32767, 32767, 32767);
    push_query(32767, -32768, 0);
    push_query(-32768, -32768, -32768);
    push_query(32767, 32767, 32767);
    push_query(0, 0, 0);
    push(KIND_CLEAR, '0);
    push_query(100, 100, 100);
    push_seg(4096, 4096, 4096, 4096, 4096, 4096);
    push_query(4096, 4096, 4096);
    push_query(-4096, 0, 8192);
    push_seg(0, 0, 0, 8192, 0, 0);
    push_query(-4096, 4096, 0);
    push_query(12288, 0, -4096);
    push_query(4096, 1, 0);
    push(KIND_SPARE, '1);
    push_query(8192, 8192, 8192);
    wait_idle();
    write_radius(15'd0);
    push_query(0, 0, 0);
    push_query(4096, 0, 0);
    wait_idle();
    write_radius(15'h7FFF);
    push_query(0, 0, 0);
    push_query(32767, 32767, 32767);
    push(KIND_CLEAR, '0, 1);
    wait_idle();

    // A larger table of random segments.
    write_radius(15'd82);
    for (int i = 0; i < 60; i++)
      push_seg(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
    push_query(rand_coord(), rand_coord(), rand_coord());
    push_query(0, 0, 0);
    push(KIND_CLEAR, '0);
    wait_idle();

    settings[0] = 15'($urandom_range(0, 15'h7FFF));
    settings[1] = 15'd0;
    settings[2] = 15'h7FFF;
    settings[3] = 15'($urandom_range(0, 2000));
    for (int ph = 0; ph < 4; ph++) begin
      write_radius(settings[ph]);
      gen_cnt = 0;
      push(KIND_CLEAR, '0);
      for (int i = 0; i < 120; i++) push_random(($urandom_range(0, 40) == 0) || i == 60);
      if (ph == 1) begin
        while (send_q.size() > 100) @(posedge clk);
        // A long hold on the result side backs the queries up into the input.
        long_hold = 4000;
      end
      wait_idle();
    end

    if (errors == 0)
      $display("tb_segment_set_distance_field_top OK");
    else
      $display("tb_segment_set_distance_field_top NOT OK");
    $finish;
  end

endmodule

### sim.f
sv/sdf_pkg.sv
sv/sdf_ram.sv
sv/sdf_dp.sv
sv/sdf_ctrl.sv
sv/segment_set_distance_field_top.sv
sim/tb_segment_set_distance_field_top.sv
